### src/hrht_pkg.sv
// Package for the HTTP request head tokenizer: shared payload types, field
// kind codes, character codes and queue sizing constants. No dependencies.
`default_nettype none

package hrht_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W = $clog2(MAX_RESULTS);

	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_URI     = 3'd1;
	localparam logic [2:0] KIND_QUERY   = 3'd2;
	localparam logic [2:0] KIND_VERSION = 3'd3;
	localparam logic [2:0] KIND_NAME    = 3'd4;
	localparam logic [2:0] KIND_VALUE   = 3'd5;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [2:0] field_kind;
		logic       byte_valid;
		logic [7:0] data_out;
		logic       field_last;
		logic       request_done;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [CNT_W-1:0]             count;
		out_t [MAX_RESULTS-1:0] res;
	} entry_t;

endpackage

`default_nettype wire

### src/hrht_front.sv
// Front end of the tokenizer: accepts input bytes, tracks the parse phase and
// builds a bundle of up to four results per item. Depends on hrht_pkg.
`default_nettype none

module hrht_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire hrht_pkg::in_t   item,
	input  wire logic            q_full,
	output logic                 q_push,
	output hrht_pkg::entry_t     q_entry
);

	typedef enum logic [10:0] {
		PH_METHOD  = 11'b000_0000_0001,
		PH_SKIP1   = 11'b000_0000_0010,
		PH_URI     = 11'b000_0000_0100,
		PH_SKIP2   = 11'b000_0000_1000,
		PH_QUERY   = 11'b000_0001_0000,
		PH_SKIP3   = 11'b000_0010_0000,
		PH_VERSION = 11'b000_0100_0000,
		PH_REST    = 11'b000_1000_0000,
		PH_NAME    = 11'b001_0000_0000,
		PH_HSKIP   = 11'b010_0000_0000,
		PH_VALUE   = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   fhb;
	} pst_t;

	typedef struct packed {
		pst_t           st;
		logic           v;
		hrht_pkg::out_t r;
	} lc_t;

	typedef struct packed {
		pst_t                 st;
		logic [1:0]           n;
		logic                 fin;
		hrht_pkg::out_t [2:0] r;
	} le_t;

	function automatic hrht_pkg::out_t mk_byte(input logic [2:0] k, input logic [7:0] c);
		hrht_pkg::out_t o;
		o = '0;
		o.field_kind = k;
		o.byte_valid = 1'b1;
		o.data_out = c;
		return o;
	endfunction

	function automatic hrht_pkg::out_t mk_close(input logic [2:0] k);
		hrht_pkg::out_t o;
		o = '0;
		o.field_kind = k;
		o.field_last = 1'b1;
		return o;
	endfunction

	function automatic hrht_pkg::out_t mk_done();
		hrht_pkg::out_t o;
		o = '0;
		o.request_done = 1'b1;
		return o;
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return (c == hrht_pkg::CH_SP) || (c == hrht_pkg::CH_TAB) || (c == hrht_pkg::CH_CR);
	endfunction

	function automatic lc_t line_char(input pst_t s, input logic [7:0] c);
		lc_t  o;
		logic sep;
		logic nsep;
		logic qm;
		o = '0;
		o.st = s;
		sep = is_sep(c);
		nsep = sep || (c == hrht_pkg::CH_COLON);
		qm = (c == hrht_pkg::CH_QMARK);
		case (s.phase)
			PH_METHOD: begin
				o.v = 1'b1;
				if (sep) begin
					o.r = mk_close(hrht_pkg::KIND_METHOD);
					o.st = '{PH_SKIP1, 1'b0};
				end else begin
					o.r = mk_byte(hrht_pkg::KIND_METHOD, c);
					o.st.fhb = 1'b1;
				end
			end
			PH_SKIP1: begin
				if (!sep) begin
					o.v = 1'b1;
					if (qm) begin
						o.r = mk_close(hrht_pkg::KIND_URI);
						o.st = '{PH_QUERY, 1'b0};
					end else begin
						o.r = mk_byte(hrht_pkg::KIND_URI, c);
						o.st = '{PH_URI, 1'b1};
					end
				end
			end
			PH_URI: begin
				o.v = 1'b1;
				if (sep) begin
					o.r = mk_close(hrht_pkg::KIND_URI);
					o.st = '{PH_SKIP2, 1'b0};
				end else if (qm) begin
					o.r = mk_close(hrht_pkg::KIND_URI);
					o.st = '{PH_QUERY, 1'b0};
				end else begin
					o.r = mk_byte(hrht_pkg::KIND_URI, c);
					o.st.fhb = 1'b1;
				end
			end
			PH_SKIP2: begin
				if (!sep) begin
					if (qm) begin
						o.st.phase = PH_QUERY;
					end else begin
						o.v = 1'b1;
						o.r = mk_byte(hrht_pkg::KIND_VERSION, c);
						o.st = '{PH_VERSION, 1'b1};
					end
				end
			end
			PH_QUERY: begin
				o.v = 1'b1;
				if (sep) begin
					o.r = mk_close(hrht_pkg::KIND_QUERY);
					o.st = '{PH_SKIP3, 1'b0};
				end else begin
					o.r = mk_byte(hrht_pkg::KIND_QUERY, c);
					o.st.fhb = 1'b1;
				end
			end
			PH_SKIP3: begin
				if (!sep) begin
					o.v = 1'b1;
					o.r = mk_byte(hrht_pkg::KIND_VERSION, c);
					o.st = '{PH_VERSION, 1'b1};
				end
			end
			PH_VERSION: begin
				o.v = 1'b1;
				if (sep) begin
					o.r = mk_close(hrht_pkg::KIND_VERSION);
					o.st = '{PH_REST, 1'b0};
				end else begin
					o.r = mk_byte(hrht_pkg::KIND_VERSION, c);
					o.st.fhb = 1'b1;
				end
			end
			PH_NAME: begin
				o.v = 1'b1;
				if (nsep) begin
					o.r = mk_close(hrht_pkg::KIND_NAME);
					o.st = '{PH_HSKIP, 1'b0};
				end else begin
					o.r = mk_byte(hrht_pkg::KIND_NAME, c);
					o.st.fhb = 1'b1;
				end
			end
			PH_HSKIP: begin
				if (!nsep) begin
					o.v = 1'b1;
					o.r = mk_byte(hrht_pkg::KIND_VALUE, c);
					o.st = '{PH_VALUE, 1'b1};
				end
			end
			PH_VALUE: begin
				o.v = 1'b1;
				o.r = mk_byte(hrht_pkg::KIND_VALUE, c);
				o.st.fhb = 1'b1;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic le_t line_end(input pst_t s);
		le_t o;
		o = '0;
		o.st = '{PH_NAME, 1'b0};
		case (s.phase)
			PH_METHOD: begin
				o.r[0] = mk_close(hrht_pkg::KIND_METHOD);
				o.r[1] = mk_close(hrht_pkg::KIND_URI);
				o.r[2] = mk_close(hrht_pkg::KIND_VERSION);
				o.n = 2'd3;
			end
			PH_SKIP1, PH_URI: begin
				o.r[0] = mk_close(hrht_pkg::KIND_URI);
				o.r[1] = mk_close(hrht_pkg::KIND_VERSION);
				o.n = 2'd2;
			end
			PH_SKIP2, PH_SKIP3, PH_VERSION: begin
				o.r[0] = mk_close(hrht_pkg::KIND_VERSION);
				o.n = 2'd1;
			end
			PH_QUERY: begin
				o.r[0] = mk_close(hrht_pkg::KIND_QUERY);
				o.r[1] = mk_close(hrht_pkg::KIND_VERSION);
				o.n = 2'd2;
			end
			PH_NAME: begin
				if (!s.fhb) begin
					o.r[0] = mk_done();
					o.n = 2'd1;
					o.fin = 1'b1;
					o.st = '{PH_METHOD, 1'b0};
				end else begin
					o.r[0] = mk_close(hrht_pkg::KIND_NAME);
					o.r[1] = mk_close(hrht_pkg::KIND_VALUE);
					o.n = 2'd2;
				end
			end
			PH_HSKIP, PH_VALUE: begin
				o.r[0] = mk_close(hrht_pkg::KIND_VALUE);
				o.n = 2'd1;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	pst_t st_q;
	logic cr_q;

	logic                                       accept;
	pst_t                                       s;
	logic                                       cr;
	logic [hrht_pkg::CNT_W-1:0]                 n;
	hrht_pkg::out_t [hrht_pkg::MAX_RESULTS-1:0] res;
	lc_t                                        lc_cr;
	lc_t                                        lc_b;
	le_t                                        le;

	assign accept = push && !q_full;

	always_comb begin
		s = st_q;
		cr = cr_q;
		n = '0;
		res = '0;
		lc_cr = line_char(s, hrht_pkg::CH_CR);
		lc_b = '0;
		le = '0;
		if ((item.operation == hrht_pkg::OP_EOS) || (item.data_byte != hrht_pkg::CH_LF)) begin
			if (cr) begin
				if (lc_cr.v) begin
					res[n[hrht_pkg::IDX_W-1:0]] = lc_cr.r;
					n = n + hrht_pkg::CNT_W'(1);
				end
				s = lc_cr.st;
				cr = 1'b0;
			end
		end
		if (item.operation == hrht_pkg::OP_BYTE) begin
			if (item.data_byte == hrht_pkg::CH_LF) begin
				cr = 1'b0;
				le = line_end(s);
				for (int i = 0; i < 3; i++) begin
					if (i < int'(le.n)) begin
						res[n[hrht_pkg::IDX_W-1:0]] = le.r[i];
						n = n + hrht_pkg::CNT_W'(1);
					end
				end
				s = le.st;
			end else if (item.data_byte == hrht_pkg::CH_CR) begin
				cr = 1'b1;
			end else begin
				lc_b = line_char(s, item.data_byte);
				if (lc_b.v) begin
					res[n[hrht_pkg::IDX_W-1:0]] = lc_b.r;
					n = n + hrht_pkg::CNT_W'(1);
				end
				s = lc_b.st;
			end
		end else begin
			le = line_end(s);
			for (int i = 0; i < 3; i++) begin
				if (i < int'(le.n)) begin
					res[n[hrht_pkg::IDX_W-1:0]] = le.r[i];
					n = n + hrht_pkg::CNT_W'(1);
				end
			end
			if (!le.fin) begin
				res[n[hrht_pkg::IDX_W-1:0]] = mk_done();
				n = n + hrht_pkg::CNT_W'(1);
			end
			s = '{PH_METHOD, 1'b0};
			cr = 1'b0;
		end
	end

	assign q_push = accept && (n != '0);
	assign q_entry = '{count: n, res: res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{PH_METHOD, 1'b0};
			cr_q <= 1'b0;
		end else if (accept) begin
			st_q <= s;
			cr_q <= cr;
		end
	end

endmodule

`default_nettype wire

### src/hrht_queue.sv
// Short register queue of result bundles between the front and back ends.
// Depends on hrht_pkg.
`default_nettype none

module hrht_queue #(
	parameter int DEPTH = hrht_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire hrht_pkg::entry_t  wr_data,
	input  wire logic              rd,
	output hrht_pkg::entry_t       head,
	output logic                   full,
	output logic                   empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	hrht_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= nxt(wp_q);
			end
			if (rd) begin
				rp_q <= nxt(rp_q);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/hrht_back.sv
// Back end of the tokenizer: walks the head bundle's results one per cycle
// into the output register unless it stalls; marks the last. Depends on hrht_pkg.
`default_nettype none

module hrht_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hrht_pkg::entry_t  head,
	input  wire logic              q_empty,
	output logic                   q_pop,
	input  wire logic              pop,
	output logic                   empty,
	output hrht_pkg::out_t         result
);

	logic                       ovld_q;
	logic [hrht_pkg::IDX_W-1:0] idx_q;
	hrht_pkg::out_t             result_q;
	logic                       take;
	logic                       is_last;
	hrht_pkg::out_t             cur;

	assign take = !q_empty && (!ovld_q || pop);
	assign is_last = ((hrht_pkg::CNT_W'(idx_q) + hrht_pkg::CNT_W'(1)) == head.count);
	assign q_pop = take && is_last;
	assign empty = !ovld_q;
	assign result = result_q;

	always_comb begin
		cur = head.res[idx_q];
		cur.last = is_last;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (take) begin
				ovld_q <= 1'b1;
				idx_q <= is_last ? '0 : idx_q + hrht_pkg::IDX_W'(1);
			end else if (pop) begin
				ovld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### src/http_request_head_tokenizer_core.sv
// HTTP request head tokenizer, top level.
// Input queue side: item (operation, data_byte) is taken when push is high and
// full is low; one byte per transaction, or an end-of-stream transaction.
// Result queue side: while empty is low, result holds the oldest tagged field
// byte, field end marker or request-done result; pop takes it.
// Each input transaction yields zero to four results; the last one of a
// transaction carries last = 1.
// The first result of a transaction passes the result queue, then the output
// register, before it shows on result. Throughput: one input transaction per
// cycle while each yields at most one result and the receiver pops; results
// leave at one per cycle while popped, so k results of a transaction hold the
// back end till all leave. The front end builds them combinationally; the
// queue (QUEUE_DEPTH bundles) between the ends sets how far input may run ahead.
// Reset clears the parse phase, the held CR and both queues.
// When the receiver stalls, the result register holds, the queue fills, and
// full rises once it holds QUEUE_DEPTH bundles.
// Depends on hrht_pkg, hrht_front, hrht_queue and hrht_back.
`default_nettype none

module http_request_head_tokenizer_core #(
	parameter int QUEUE_DEPTH = hrht_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire hrht_pkg::in_t   item,
	output logic                 empty,
	input  wire logic            pop,
	output hrht_pkg::out_t       result
);

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	hrht_pkg::entry_t q_entry;
	hrht_pkg::entry_t q_head;

	assign full = q_full;

	hrht_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	hrht_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_entry),
		.rd      (q_pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	hrht_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef SYNTH
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("result queue both full and empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("bundle written into a full queue");

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_entry.count != '0))
		else $error("empty bundle written into the queue");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.request_done) |-> (!result.byte_valid && !result.field_last
			&& result.last))
		else $error("malformed request done result");
`endif

endmodule

`default_nettype wire
